>>> sv/slot_pool_allocator_core_defines.svh
// Assertion macros shared by the slot pool allocator RTL.
`ifndef SLOT_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define SLOT_POOL_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/spa_pkg.sv
// Types and constants of the slot pool allocator.
`timescale 1ns / 1ps
package spa_pkg;

  localparam int HANDLE_W = 8;
  localparam int KIND_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_TRY   = 2'd1,
    FN_FREE  = 2'd2,
    FN_RSVD  = 2'd3
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    ST_OK        = 2'd0,
    ST_NONE      = 2'd1,
    ST_INVALID   = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

endpackage

>>> sv/spa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/slot_pool_allocator_core.sv
// Top level of the slot pool allocator: request decode, RAM read-modify-write, result register.
// Slot pool allocator. Each request item (in_tuser = kind, in_tdata = handle
// to release) produces exactly one result item (out_tdata = handle granted,
// out_tuser = status). Allocate reuses the oldest freed handle, else issues
// the next never-issued handle, else reports exhausted; try-allocate only
// reuses a freed handle; deallocate queues an allocated handle or reports an
// invalid release. Kind 3 is reserved and reports invalid. handle_out is 0
// whenever status is not ok. Freed handles sit in a FIFO RAM and the
// allocated marks in a 1-bit RAM, both POOL_SIZE deep. A mark at or above the
// fresh counter has never been written and is ignored on release, so no clearing
// pass is needed after reset and the block takes items from the first cycle.
// The block takes no new item while one executes. The request cycle launches the RAM
// reads (queue head, mark of the released handle); the following cycle uses
// the registered read data, writes both RAMs back and loads the result
// register. A waiting result does not block the next item as long as the
// sink takes it no later than the cycle the next item is accepted.
`timescale 1ns / 1ps
`include "slot_pool_allocator_core_defines.svh"
module slot_pool_allocator_core #(
  parameter int POOL_SIZE = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [spa_pkg::HANDLE_W-1:0] in_tdata,  // [7:0] handle_in
  input  logic [spa_pkg::KIND_W-1:0]   in_tuser,  // [1:0] func
  // result channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [spa_pkg::HANDLE_W-1:0] out_tdata, // [7:0] handle_out
  output logic [spa_pkg::KIND_W-1:0]   out_tuser  // [1:0] status
);

  import spa_pkg::*;

  localparam int HW = $clog2(POOL_SIZE);      // slot index width
  localparam int CW = $clog2(POOL_SIZE + 1);  // counts up to POOL_SIZE
  localparam int XW = 17;                     // compare width for any handle
  localparam logic [HW-1:0] LAST_IDX = HW'(POOL_SIZE - 1);
  localparam logic [CW-1:0] POOL_CNT = CW'(POOL_SIZE);

  // control
  logic busy_r, busy_nxt;
  logic out_valid_r, out_valid_nxt;
  // latched request
  func_t                func_r, func_nxt;
  logic [HANDLE_W-1:0]  hin_r, hin_nxt;
  // queue and pool state
  logic [HW-1:0] head_r, head_nxt;
  logic [HW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] fresh_r, fresh_nxt;
  // result register
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  status_t             out_status_r, out_status_nxt;

  // RAM ports
  logic                q_we;
  logic [HANDLE_W-1:0] q_rdata;
  logic                m_we;
  logic [HW-1:0]       m_waddr;
  logic                m_wdata;
  logic                m_rdata;

  logic in_acc;
  logic q_empty;
  logic rel_ok;

  assign in_tready  = !busy_r && (!out_valid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_handle_r;
  assign out_tuser  = out_status_r;

  assign q_empty = (count_r == '0);

  // A release is good only for an issued handle whose mark is set.
  assign rel_ok = (XW'(hin_r) < XW'(POOL_SIZE)) && (XW'(hin_r) < XW'(fresh_r)) &&
                  m_rdata && (count_r != POOL_CNT);

  // freed-handle FIFO storage; read at the head on every accepted item
  spa_ram #(.WIDTH(HANDLE_W), .DEPTH(POOL_SIZE)) u_queue_ram (
    .clk  (clk),
    .we   (q_we),
    .waddr(tail_r),
    .wdata(hin_r),
    .raddr(head_r),
    .rdata(q_rdata)
  );

  // allocated marks; read at the released handle on every accepted item
  spa_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_mark_ram (
    .clk  (clk),
    .we   (m_we),
    .waddr(m_waddr),
    .wdata(m_wdata),
    .raddr(HW'(in_tdata)),
    .rdata(m_rdata)
  );

  always_comb begin
    busy_nxt       = busy_r;
    out_valid_nxt  = out_valid_r;
    func_nxt       = func_r;
    hin_nxt        = hin_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    fresh_nxt      = fresh_r;
    out_handle_nxt = out_handle_r;
    out_status_nxt = out_status_r;
    q_we           = 1'b0;
    m_we           = 1'b0;
    m_waddr        = HW'(hin_r);
    m_wdata        = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      // RAM reads launch this cycle; work happens next cycle
      busy_nxt = 1'b1;
      func_nxt = func_t'(in_tuser);
      hin_nxt  = in_tdata;
    end

    if (busy_r) begin
      busy_nxt       = 1'b0;
      out_valid_nxt  = 1'b1;   // result slot is known empty here
      out_handle_nxt = '0;
      out_status_nxt = ST_INVALID;
      case (func_r)
        FN_ALLOC, FN_TRY: begin
          if (!q_empty) begin
            // reuse oldest freed handle
            out_handle_nxt = q_rdata;
            out_status_nxt = ST_OK;
            head_nxt       = (head_r == LAST_IDX) ? '0 : head_r + HW'(1);
            count_nxt      = count_r - CW'(1);
            m_we           = 1'b1;
            m_waddr        = HW'(q_rdata);
            m_wdata        = 1'b1;
          end else if (func_r == FN_TRY) begin
            out_status_nxt = ST_NONE;
          end else if (fresh_r != POOL_CNT) begin
            // issue a never-used handle
            out_handle_nxt = HANDLE_W'(fresh_r);
            out_status_nxt = ST_OK;
            fresh_nxt      = fresh_r + CW'(1);
            m_we           = 1'b1;
            m_waddr        = HW'(fresh_r);
            m_wdata        = 1'b1;
          end else begin
            out_status_nxt = ST_EXHAUSTED;
          end
        end
        FN_FREE: begin
          if (rel_ok) begin
            out_status_nxt = ST_OK;
            m_we           = 1'b1;
            m_waddr        = HW'(hin_r);
            m_wdata        = 1'b0;
            q_we           = 1'b1;
            tail_nxt       = (tail_r == LAST_IDX) ? '0 : tail_r + HW'(1);
            count_nxt      = count_r + CW'(1);
          end
        end
        default: begin
          out_status_nxt = ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
    end
    func_r       <= func_nxt;
    hin_r        <= hin_nxt;
    out_handle_r <= out_handle_nxt;
    out_status_r <= out_status_nxt;
  end

  `SPA_ASSERT_NXT(a_acc_busy, clk, rst_n, in_acc, busy_r && !in_tready, "accepted item did not enter the execute cycle")
  `SPA_ASSERT_IMP(a_busy_slot, clk, rst_n, busy_r, !out_valid_r, "result register occupied while an item executes")
  `SPA_ASSERT_IMP(a_rise_exec, clk, rst_n, $rose(out_valid_r), $past(busy_r), "result appeared without an execute cycle")
  `SPA_ASSERT_IMP(a_count_lim, clk, rst_n, 1'b1, (count_r <= fresh_r) && (fresh_r <= POOL_CNT), "queue count exceeds handles issued")
  `SPA_ASSERT_NXT(a_held, clk, rst_n, out_valid_r && !out_tready, out_valid_r && $stable(out_handle_r) && $stable(out_status_r), "stalled result changed")

endmodule
